// File: rtl/ffra_pkg.sv
package ffra_pkg;

	localparam int MAX_CHUNKS_DEF  = 16;
	localparam int OFFSET_BITS_DEF = 20;

	localparam int SIZE_W   = 20;
	localparam int REGION_W = 21;
	localparam int HDR_W    = 8;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam logic [REGION_W-1:0] REGION_BYTES_RST = REGION_W'(65536);
	localparam logic [HDR_W-1:0]    NODE_HDR_RST     = HDR_W'(32);
	localparam logic [HDR_W-1:0]    REGION_HDR_RST   = HDR_W'(16);

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_REGION_BYTES = 2'd0;
	localparam logic [1:0] REG_NODE_HDR     = 2'd1;
	localparam logic [1:0] REG_REGION_HDR   = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_ROOM    = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_NOT_FOUND  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_TAIL,
		S_INS,
		S_REM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [REGION_W-1:0] region_bytes;
		logic [HDR_W-1:0]    node_hdr;
		logic [HDR_W-1:0]    region_hdr;
	} cfg_t;

	typedef struct packed {
		logic    load;
		logic    check;
		logic    walk;
		logic    empty_pos;
		logic    tail;
		logic    shift_up;
		logic    shift_dn;
		logic    put;
		logic    drop;
		logic    code_we;
		status_t code;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		logic op_free;
		logic empty;
		logic full;
		logic room_fail;
		logic walk_hit;
		logic walk_last;
		logic tail_fit;
		logic ins_idle;
		logic rem_idle;
		logic out_free;
	} stat_t;

endpackage

// File: rtl/ffra_if.sv
interface ffra_req_if import ffra_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [SIZE_W-1:0] request_size;
	logic [SIZE_W-1:0] free_offset;

	modport source (output valid, opcode, request_size, free_offset, input ready);
	modport sink (input valid, opcode, request_size, free_offset, output ready);
endinterface

interface ffra_rsp_if import ffra_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [SIZE_W-1:0] data_offset;

	modport source (output valid, status, data_offset, input ready);
	modport sink (input valid, status, data_offset, output ready);
endinterface

// File: rtl/ffra_ctrl.sv
module ffra_ctrl import ffra_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_CHECK;
			end
			S_CHECK: begin
				priority if (stat.op_free) begin
					state_nx = stat.empty ? S_DONE : S_WALK;
				end else if (stat.room_fail || stat.full) begin
					state_nx = S_DONE;
				end else if (stat.empty) begin
					state_nx = S_INS;
				end else begin
					state_nx = S_WALK;
				end
			end
			S_WALK: begin
				priority if (stat.walk_hit) begin
					state_nx = stat.op_free ? S_REM : S_INS;
				end else if (stat.walk_last) begin
					state_nx = stat.op_free ? S_DONE : S_TAIL;
				end else begin
					state_nx = S_WALK;
				end
			end
			S_TAIL: begin
				state_nx = stat.tail_fit ? S_INS : S_DONE;
			end
			S_INS: begin
				if (stat.ins_idle) state_nx = S_DONE;
			end
			S_REM: begin
				if (stat.rem_idle) state_nx = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.code = ST_OK;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				priority if (stat.op_free) begin
					cmd.code_we = stat.empty;
					cmd.code    = ST_NOT_FOUND;
				end else if (stat.room_fail) begin
					cmd.code_we = 1'b1;
					cmd.code    = ST_NO_ROOM;
				end else if (stat.full) begin
					cmd.code_we = 1'b1;
					cmd.code    = ST_TABLE_FULL;
				end else begin
					cmd.empty_pos = stat.empty;
				end
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (!stat.walk_hit && stat.walk_last && stat.op_free) begin
					cmd.code_we = 1'b1;
					cmd.code    = ST_NOT_FOUND;
				end
			end
			S_TAIL: begin
				if (stat.tail_fit) begin
					cmd.tail = 1'b1;
				end else begin
					cmd.code_we = 1'b1;
					cmd.code    = ST_NO_ROOM;
				end
			end
			S_INS: begin
				if (stat.ins_idle) begin
					cmd.put     = 1'b1;
					cmd.code_we = 1'b1;
					cmd.code    = ST_OK;
				end else begin
					cmd.shift_up = 1'b1;
				end
			end
			S_REM: begin
				if (stat.rem_idle) begin
					cmd.drop    = 1'b1;
					cmd.code_we = 1'b1;
					cmd.code    = ST_OK;
				end else begin
					cmd.shift_dn = 1'b1;
				end
			end
			S_DONE: begin
				cmd.emit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: rtl/ffra_dpath.sv
module ffra_dpath import ffra_pkg::*; #(
	parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic              in_opcode,
	input  logic [SIZE_W-1:0] in_request_size,
	input  logic [SIZE_W-1:0] in_free_offset,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_status,
	output logic [SIZE_W-1:0] out_data_offset
);

	localparam int OB = OFFSET_BITS;
	localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CW = $clog2(MAX_CHUNKS + 1);
	localparam int MW = SIZE_W + OB;
	// start + header + size + need, with headroom
	localparam int EW = ((OB > SIZE_W) ? OB : SIZE_W) + 3;

	// table entry: {size, header offset}
	logic [MW-1:0] mem [MAX_CHUNKS];
	logic [MW-1:0] rd_q;
	logic [AW-1:0] ra, wa;
	logic [MW-1:0] wd;
	logic          we;

	logic                op_q;
	logic [SIZE_W-1:0]   size_q;
	logic [SIZE_W-1:0]   ofs_q;
	logic [REGION_W-1:0] need_q;
	logic [CW-1:0]       cnt_q;
	logic [AW-1:0]       cur_q;
	logic [EW-1:0]       cend_q;
	logic [CW-1:0]       pos_q;
	logic [OB-1:0]       pos_start_q;
	logic [CW-1:0]       t_q;
	logic                mv_v_q;
	logic [AW-1:0]       wa_q;
	status_t             code_q;

	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [SIZE_W-1:0]   data_q;

	logic [OB-1:0]     cur_start;
	logic [SIZE_W-1:0] cur_size;
	logic [EW-1:0]     cend_cur;
	logic [EW-1:0]     end_e;
	logic [EW-1:0]     mask_e;
	logic [EW-1:0]     rb_e;
	logic [CW-1:0]     tm1;
	logic [CW-1:0]     cur_c;
	logic              gap_fit;
	logic              free_match;
	logic [OB-1:0]     dsum;

	assign cur_start = rd_q[OB-1:0];
	assign cur_size  = rd_q[MW-1:OB];
	assign cur_c     = CW'(cur_q);
	assign tm1       = t_q - CW'(1);

	assign cend_cur = EW'(cur_start) + EW'(cfg.node_hdr) + EW'(cur_size);
	assign mask_e   = (EW'(1) << OB) - EW'(1);
	assign rb_e     = EW'(cfg.region_bytes);
	assign end_e    = (rb_e > mask_e) ? mask_e : rb_e;

	assign gap_fit    = EW'(cur_start) >= cend_q + EW'(need_q);
	assign free_match = (EW'(cur_start) + EW'(cfg.node_hdr)) == EW'(ofs_q);
	assign dsum       = pos_start_q + OB'(cfg.node_hdr);

	always_comb begin
		stat           = '0;
		stat.op_free   = op_q;
		stat.empty     = (cnt_q == '0);
		stat.full      = (cnt_q >= CW'(MAX_CHUNKS));
		stat.room_fail = end_e < (EW'(cfg.region_hdr) + EW'(need_q));
		stat.walk_hit  = op_q ? free_match : ((cur_q != '0) && gap_fit);
		stat.walk_last = (cur_c == (cnt_q - CW'(1)));
		stat.tail_fit  = !(end_e < (cend_q + EW'(need_q)));
		stat.ins_idle  = (t_q == pos_q) && !mv_v_q;
		stat.rem_idle  = (t_q >= cnt_q) && !mv_v_q;
		stat.out_free  = !out_valid_q || out_ready;
	end

	// read address and write port
	always_comb begin
		ra = '0;
		priority if (cmd.walk) begin
			ra = cur_q + AW'(1);
		end else if (cmd.shift_up) begin
			ra = tm1[AW-1:0];
		end else if (cmd.shift_dn) begin
			ra = t_q[AW-1:0];
		end else begin
			ra = '0;
		end
	end

	always_comb begin
		we = 1'b0;
		wa = wa_q;
		wd = rd_q;
		priority if (cmd.put) begin
			we = 1'b1;
			wa = pos_q[AW-1:0];
			wd = {size_q, pos_start_q};
		end else if (cmd.shift_up || cmd.shift_dn) begin
			we = mv_v_q;
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	// item payload, walk and shift state, and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_opcode;
			size_q <= in_request_size;
			ofs_q  <= in_free_offset;
			need_q <= REGION_W'(in_request_size) + REGION_W'(cfg.node_hdr);
		end
		if (cmd.check) begin
			cur_q <= '0;
		end else if (cmd.walk) begin
			cur_q  <= cur_q + AW'(1);
			cend_q <= cend_cur;
		end
		if (cmd.empty_pos) begin
			pos_q       <= '0;
			pos_start_q <= OB'(cfg.region_hdr);
			t_q         <= cnt_q;
		end else if (cmd.tail) begin
			pos_q       <= cnt_q;
			pos_start_q <= cend_q[OB-1:0];
			t_q         <= cnt_q;
		end else if (cmd.walk && stat.walk_hit) begin
			pos_q       <= cur_c;
			pos_start_q <= cend_q[OB-1:0];
			t_q         <= op_q ? (cur_c + CW'(1)) : cnt_q;
		end else if (cmd.shift_up && (t_q > pos_q)) begin
			t_q <= tm1;
		end else if (cmd.shift_dn && (t_q < cnt_q)) begin
			t_q <= t_q + CW'(1);
		end
		if (cmd.shift_up) begin
			wa_q <= t_q[AW-1:0];
		end else if (cmd.shift_dn) begin
			wa_q <= tm1[AW-1:0];
		end
		if (cmd.code_we) code_q <= cmd.code;
		if (cmd.emit) begin
			status_q <= code_q;
			data_q   <= ((code_q == ST_OK) && (op_q == OP_ALLOC)) ? SIZE_W'(dsum) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			mv_v_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.put) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.drop) begin
				cnt_q <= cnt_q - CW'(1);
			end
			priority if (cmd.shift_up) begin
				mv_v_q <= (t_q > pos_q);
			end else if (cmd.shift_dn) begin
				mv_v_q <= (t_q < cnt_q);
			end else begin
				mv_v_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_status      = status_q;
	assign out_data_offset = data_q;

endmodule

// File: rtl/first_fit_region_allocator.sv
// channel  dir  beat fields                              handshake
// req      in   opcode, request_size, free_offset        valid/ready
// rsp      out  status, data_offset                      valid/ready
// apb      in   region_bytes, node_hdr, region_hdr       psel/penable/pwrite
//
// One item at a time. An allocate walks w of the n live chunk entries and
// moves m entries up (each one table port access), a free walks w and moves
// m entries down. The walk and the shift share the single read and single
// write port of the chunk table. Reset clears the chunk count, the controller
// state and the valid flags; the table needs no clear.
// req is held off while an item is in flight; a result waiting on rsp does not
// block the next request beat.
module first_fit_region_allocator import ffra_pkg::*; #(
	parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	ffra_req_if.sink           req,
	ffra_rsp_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_bytes <= REGION_BYTES_RST;
			cfg_q.node_hdr     <= NODE_HDR_RST;
			cfg_q.region_hdr   <= REGION_HDR_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_REGION_BYTES: cfg_q.region_bytes <= pwdata[REGION_W-1:0];
				REG_NODE_HDR:     cfg_q.node_hdr     <= pwdata[HDR_W-1:0];
				REG_REGION_HDR:   cfg_q.region_hdr   <= pwdata[HDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_REGION_BYTES: prdata = PDATA_W'(cfg_q.region_bytes);
			REG_NODE_HDR:     prdata = PDATA_W'(cfg_q.node_hdr);
			REG_REGION_HDR:   prdata = PDATA_W'(cfg_q.region_hdr);
			default:          prdata = '0;
		endcase
	end

	ffra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffra_dpath #(
		.MAX_CHUNKS  (MAX_CHUNKS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.cmd             (cmd),
		.stat            (stat),
		.in_opcode       (req.opcode),
		.in_request_size (req.request_size),
		.in_free_offset  (req.free_offset),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_status      (rsp.status),
		.out_data_offset (rsp.data_offset)
	);

	// no second request beat while one is in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while an item is in flight");

	a_put_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> !stat.full)
		else $error("chunk inserted into a full table");

	a_drop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |-> !stat.empty)
		else $error("chunk removed from an empty table");

	// a result must never overwrite one still waiting on rsp
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!rsp.valid || rsp.ready))
		else $error("result overwrites a pending beat");

endmodule
